FILE: rtl/bitrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bitrd_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
    localparam int WORD_W     = 32;
    localparam int ZCNT_MAX   = (FIFO_DEPTH * WORD_W > 1023) ? FIFO_DEPTH * WORD_W : 1023;
    localparam int ZCNT_W     = $clog2(ZCNT_MAX + 1);

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_GET   = 2'd1,
        FUNC_ZEROS = 2'd2,
        FUNC_ALIGN = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNDERRUN = 2'd1,
        ST_REFUSED  = 2'd2
    } status_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] word;
        logic [5:0]  bit_count;
        logic [9:0]  max_zeros;
    } cmd_t;

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
    } rsp_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic rd;
    } fifo_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == ADDR_W'(FIFO_DEPTH - 1))
            r = '0;
        else
            r = p + ADDR_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bitrd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module bitrd_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bitrd_pkg::fifo_ctl_t  ctl,
    input  wire logic [31:0]           wdata,
    output bitrd_pkg::fifo_stat_t      stat,
    output logic [31:0]                rdata
);

    logic [31:0]                   mem [bitrd_pkg::FIFO_DEPTH];
    logic [bitrd_pkg::ADDR_W-1:0]  head_reg;
    logic [bitrd_pkg::ADDR_W-1:0]  tail_reg;
    logic [bitrd_pkg::FILL_W-1:0]  fill_reg;
    logic [bitrd_pkg::FILL_W-1:0]  fill_next;
    logic [31:0]                   rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            mem[tail_reg] <= wdata;
        if (ctl.rd)
            rdata_reg <= mem[head_reg];
    end

    always_comb
    begin
        fill_next = fill_reg;
        case ({ctl.push, ctl.pop})
            2'b10:   fill_next = fill_reg + bitrd_pkg::FILL_W'(1);
            2'b01:   fill_next = fill_reg - bitrd_pkg::FILL_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (ctl.push)
                tail_reg <= bitrd_pkg::ptr_inc(tail_reg);
            if (ctl.pop)
                head_reg <= bitrd_pkg::ptr_inc(head_reg);
            fill_reg <= fill_next;
        end
    end

    assign stat.full  = (fill_reg == bitrd_pkg::FILL_W'(bitrd_pkg::FIFO_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign rdata      = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/bitrd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bitrd_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_stall,
    input  wire bitrd_pkg::cmd_t        cmd,
    output logic                        res_valid,
    input  wire logic                   res_take,
    output bitrd_pkg::rsp_t             res,
    output bitrd_pkg::fifo_ctl_t        fifo_ctl,
    output logic [31:0]                 fifo_wdata,
    input  wire bitrd_pkg::fifo_stat_t  fifo_stat,
    input  wire logic [31:0]            fifo_rdata
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_STEP     = 5'b00100,
        S_LOAD     = 5'b01000,
        S_DONE     = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    bitrd_pkg::cmd_t               req_reg, req_next;
    bitrd_pkg::rsp_t               res_reg, res_next;
    logic [31:0]                   cur_reg, cur_next;
    logic                          cur_vld_reg, cur_vld_next;
    logic [4:0]                    pos_reg, pos_next;
    logic                          flag_reg, flag_next;
    logic [5:0]                    rem_reg, rem_next;
    logic [31:0]                   val_reg, val_next;
    logic [bitrd_pkg::ZCNT_W-1:0]  zcnt_reg, zcnt_next;

    logic                          bit_in;
    logic [31:0]                   val_shift;
    logic [bitrd_pkg::ZCNT_W-1:0]  zcnt_inc;
    logic [5:0]                    nbits;

    assign bit_in    = cur_reg[31];
    assign val_shift = {val_reg[30:0], bit_in};
    assign zcnt_inc  = zcnt_reg + bitrd_pkg::ZCNT_W'(1);
    assign nbits     = (req_reg.bit_count > 6'd32) ? 6'd32 : req_reg.bit_count;

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        cur_next     = cur_reg;
        cur_vld_next = cur_vld_reg;
        pos_next     = pos_reg;
        flag_next    = flag_reg;
        rem_next     = rem_reg;
        val_next     = val_reg;
        zcnt_next    = zcnt_reg;
        fifo_ctl     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    req_next   = cmd;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                res_next   = '{value: '0, status: bitrd_pkg::ST_OK};
                val_next   = '0;
                zcnt_next  = '0;
                rem_next   = nbits;
                state_next = S_DONE;
                if (req_reg.func == bitrd_pkg::FUNC_PUSH)
                begin
                    if (fifo_stat.full)
                        res_next.status = bitrd_pkg::ST_REFUSED;
                    else
                    begin
                        fifo_ctl.push = 1'b1;
                        if (flag_reg)
                            res_next.status = bitrd_pkg::ST_UNDERRUN;
                    end
                end
                else if (flag_reg)
                begin
                    res_next.status = bitrd_pkg::ST_UNDERRUN;
                    if (req_reg.func != bitrd_pkg::FUNC_ALIGN)
                        res_next.value = '1;
                end
                else
                begin
                    unique case (req_reg.func)
                        bitrd_pkg::FUNC_GET:
                        begin
                            if (nbits != 6'd0)
                                state_next = S_STEP;
                        end
                        bitrd_pkg::FUNC_ZEROS:
                            state_next = S_STEP;
                        bitrd_pkg::FUNC_ALIGN:
                        begin
                            if (pos_reg != 5'd0 && !fifo_stat.empty)
                            begin
                                fifo_ctl.pop = 1'b1;
                                cur_vld_next = 1'b0;
                            end
                            pos_next = '0;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end

            S_STEP:
            begin
                if (!cur_vld_reg)
                begin
                    if (fifo_stat.empty)
                    begin
                        flag_next  = 1'b1;
                        res_next   = '{value: '1, status: bitrd_pkg::ST_UNDERRUN};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        fifo_ctl.rd = 1'b1;
                        state_next  = S_LOAD;
                    end
                end
                else
                begin
                    // consume one bit off the head word
                    cur_next = {cur_reg[30:0], 1'b0};
                    pos_next = pos_reg + 5'd1;
                    if (pos_reg == 5'd31)
                    begin
                        fifo_ctl.pop = 1'b1;
                        cur_vld_next = 1'b0;
                    end
                    if (req_reg.func == bitrd_pkg::FUNC_GET)
                    begin
                        val_next = val_shift;
                        rem_next = rem_reg - 6'd1;
                        if (rem_reg == 6'd1)
                        begin
                            res_next   = '{value: val_shift, status: bitrd_pkg::ST_OK};
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        if (bit_in)
                        begin
                            res_next   = '{value: 32'(zcnt_reg), status: bitrd_pkg::ST_OK};
                            state_next = S_DONE;
                        end
                        else
                        begin
                            zcnt_next = zcnt_inc;
                            if (req_reg.max_zeros != 10'd0 &&
                                zcnt_inc == bitrd_pkg::ZCNT_W'(req_reg.max_zeros))
                            begin
                                res_next   = '{value: 32'(zcnt_inc),
                                               status: bitrd_pkg::ST_OK};
                                state_next = S_DONE;
                            end
                        end
                    end
                end
            end

            S_LOAD:
            begin
                cur_next     = fifo_rdata;
                cur_vld_next = 1'b1;
                state_next   = S_STEP;
            end

            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cur_vld_reg <= 1'b0;
            pos_reg     <= '0;
            flag_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_vld_reg <= cur_vld_next;
            pos_reg     <= pos_next;
            flag_reg    <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        res_reg  <= res_next;
        cur_reg  <= cur_next;
        rem_reg  <= rem_next;
        val_reg  <= val_next;
        zcnt_reg <= zcnt_next;
    end

    assign cmd_stall  = (state_reg != S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res        = res_reg;
    assign fifo_wdata = req_reg.word;

    a_cur_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        cur_vld_reg |-> !fifo_stat.empty)
        else $error("head word loaded while fifo empty");

    a_pos_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != 5'd0) |-> cur_vld_reg)
        else $error("bit position set without a loaded head word");

    a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg |=> flag_reg)
        else $error("underrun flag cleared");

    a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> $past(fifo_ctl.rd))
        else $error("head word taken without a read");

endmodule

`default_nettype wire

FILE: rtl/msb_first_bit_reader_top.sv
// MSB-first bitstream reader.
// cmd channel (cmd_valid / cmd_stall / cmd): one request per handshake:
// push a word, get up to 32 bits, count zeros up to a nonzero max_zeros, or align.
// rsp channel (rsp_valid / rsp_stall / rsp): one response per request,
// in order, from an output register.
// Words sit in a 16-entry FIFO; the head word is held in a shift register
// and consumed one bit per cycle, pausing while a head word is fetched.
// A request is dispatched, then get bits and count zeros step through the
// head word register one bit at a time, fetching head words from the FIFO
// as needed; push, align and requests answered from the underrun flag
// finish at dispatch.
// A new request is taken the cycle after the previous response has moved
// into the output register; the core works on one request at a time.
// While rsp_stall holds the output register, one more request may finish
// and then waits inside the core.
// Reset empties the FIFO, clears the bit position and the underrun flag.
`timescale 1ns / 1ps
`default_nettype none

module msb_first_bit_reader_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire bitrd_pkg::cmd_t  cmd,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output bitrd_pkg::rsp_t       rsp
);

    bitrd_pkg::fifo_ctl_t   fifo_ctl;
    bitrd_pkg::fifo_stat_t  fifo_stat;
    logic [31:0]            fifo_wdata;
    logic [31:0]            fifo_rdata;
    logic                   res_valid;
    logic                   res_take;
    bitrd_pkg::rsp_t        res;
    logic                   out_vld_reg;
    bitrd_pkg::rsp_t        out_reg;

    bitrd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fifo_ctl),
        .wdata (fifo_wdata),
        .stat  (fifo_stat),
        .rdata (fifo_rdata)
    );

    bitrd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .fifo_ctl   (fifo_ctl),
        .fifo_wdata (fifo_wdata),
        .fifo_stat  (fifo_stat),
        .fifo_rdata (fifo_rdata)
    );

    assign res_take = res_valid && (!out_vld_reg || !rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (res_take)
            out_vld_reg <= 1'b1;
        else if (!rsp_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_reg <= res;
    end

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire
